// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the frame checker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define UFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define UFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ufc_pkg.sv =====
// ---------------------------------------------------------------------------
// UART frame checker package
// Constants, types and the CRC-16/Modbus byte update shared by the RTL.
// ---------------------------------------------------------------------------
`default_nettype none

package ufc_pkg;

    localparam int DATA_BYTES = 256;

    localparam int POS_DATA = 5;
    localparam int POS_DCRC = POS_DATA + DATA_BYTES;
    localparam int POS_CCRC = POS_DCRC + 2;
    localparam int POS_END  = POS_CCRC + 2;
    localparam int POS_W    = $clog2(POS_END + 1);

    localparam int IDX_W    = 12;
    localparam int ADDR_W   = 24;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  BLANK_BYTE = 8'hFF;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BLANK    = 3'd1,
        ST_SHORT    = 3'd2,
        ST_BAD_HEAD = 3'd3,
        ST_DATA_CRC = 3'd4,
        ST_CMD_CRC  = 3'd5,
        ST_BAD_END  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_OTHER = 2'd2
    } op_kind_t;

    typedef enum logic [1:0] {
        REG_HEAD = 2'd0,
        REG_END  = 2'd1,
        REG_OP   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] end_byte;
        op_kind_t   op_kind;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       abort;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic [IDX_W-1:0]  data_index;
        status_t           status;
        logic [7:0]        cmd;
        logic [ADDR_W-1:0] address;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ufc_channels.sv =====
// ---------------------------------------------------------------------------
// UART frame checker channels
// Valid/ready interfaces for received bytes and for checker results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ufc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       abort;

    modport source (output valid, output rx_byte, output abort, input ready);
    modport sink   (input valid, input rx_byte, input abort, output ready);
endinterface

interface ufc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [7:0]                 data_byte;
    logic [ufc_pkg::IDX_W-1:0]  data_index;
    logic [2:0]                 status;
    logic [7:0]                 cmd;
    logic [ufc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output kind, output data_byte, output data_index,
                    output status, output cmd, output address, input ready);
    modport sink   (input valid, input kind, input data_byte, input data_index,
                    input status, input cmd, input address, output ready);
endinterface

`default_nettype wire

// ===== rtl/ufc_apb_regs.sv =====
// ---------------------------------------------------------------------------
// UART frame checker configuration registers
// APB-style register file holding head byte, end byte and operation kind.
// ---------------------------------------------------------------------------
`default_nettype none

module ufc_apb_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ufc_pkg::APB_AW-1:0] paddr,
    input  wire logic [ufc_pkg::APB_DW-1:0] pwdata,
    output logic      [ufc_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output ufc_pkg::cfg_t                   cfg
);
    import ufc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_HEAD: cfg_next.head_byte = pwdata[7:0];
                REG_END:  cfg_next.end_byte  = pwdata[7:0];
                REG_OP:   cfg_next.op_kind   = op_kind_t'(pwdata[1:0]);
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_HEAD: prdata = {{(APB_DW-8){1'b0}}, cfg_reg.head_byte};
            REG_END:  prdata = {{(APB_DW-8){1'b0}}, cfg_reg.end_byte};
            REG_OP:   prdata = {{(APB_DW-2){1'b0}}, cfg_reg.op_kind};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_byte <= 8'h00;
            cfg_reg.end_byte  <= 8'h00;
            cfg_reg.op_kind   <= OP_OTHER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ufc_in_stage.sv =====
// ---------------------------------------------------------------------------
// UART frame checker input stage
// Registers each received byte transfer ahead of the frame engine.
// ---------------------------------------------------------------------------
`default_nettype none

module ufc_in_stage (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ufc_in_if.sink        in_ch,
    output logic          s1_valid,
    output ufc_pkg::item_t s1_item,
    input  wire logic     take
);
    import ufc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_ch.ready = !valid_reg || take;
    assign accept      = in_ch.valid && in_ch.ready;
    assign s1_valid    = valid_reg;
    assign s1_item     = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.rx_byte <= in_ch.rx_byte;
            item_reg.abort   <= in_ch.abort;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ufc_frame_engine.sv =====
// ---------------------------------------------------------------------------
// UART frame checker frame engine
// Tracks frame position and CRCs and registers data and status results.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ufc_frame_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ufc_pkg::cfg_t   cfg,
    input  wire logic            s1_valid,
    input  wire ufc_pkg::item_t  s1_item,
    output logic                 take,
    ufc_out_if.source            out_ch
);
    import ufc_pkg::*;

    logic [POS_W-1:0]  pos_reg,        pos_next;
    logic              head_good_reg,  head_good_next;
    logic              all_ones_reg,   all_ones_next;
    logic [15:0]       dcrc_reg,       dcrc_next;
    logic [15:0]       ccrc_reg,       ccrc_next;
    logic [15:0]       dcrc_rx_reg,    dcrc_rx_next;
    logic [15:0]       ccrc_rx_reg,    ccrc_rx_next;
    logic [7:0]        cmd_reg,        cmd_next;
    logic [ADDR_W-1:0] addr_reg,       addr_next;
    logic              out_valid_reg,  out_valid_next;
    result_t           out_res_reg;

    result_t           res;
    logic              has_res;
    logic              blank;
    logic              crc_enforced;
    logic [7:0]        b;

    assign b            = s1_item.rx_byte;
    assign blank        = all_ones_reg && (dcrc_rx_reg == CRC_INIT);
    assign crc_enforced = (cfg.op_kind == OP_READ) || (cfg.op_kind == OP_WRITE);
    assign take         = s1_valid && (!has_res || !out_valid_reg || out_ch.ready);

    always_comb
    begin
        pos_next       = pos_reg + POS_W'(1);
        head_good_next = head_good_reg;
        all_ones_next  = all_ones_reg;
        dcrc_next      = dcrc_reg;
        ccrc_next      = ccrc_reg;
        dcrc_rx_next   = dcrc_rx_reg;
        ccrc_rx_next   = ccrc_rx_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        res            = '0;
        has_res        = 1'b0;

        if (s1_item.abort || pos_reg >= POS_W'(POS_END))
        begin
            has_res     = 1'b1;
            res.kind    = KIND_STATUS;
            res.cmd     = cmd_reg;
            res.address = addr_reg;
            if (s1_item.abort)
            begin
                res.status = ST_SHORT;
            end
            else if (!head_good_reg)
            begin
                res.status = ST_BAD_HEAD;
            end
            else if (!blank && dcrc_reg != dcrc_rx_reg && crc_enforced)
            begin
                res.status = ST_DATA_CRC;
            end
            else if (ccrc_reg != ccrc_rx_reg)
            begin
                res.status = ST_CMD_CRC;
            end
            else if (b != cfg.end_byte)
            begin
                res.status = ST_BAD_END;
            end
            else if (blank && cfg.op_kind == OP_READ)
            begin
                res.status = ST_BLANK;
            end
            else
            begin
                res.status = ST_OK;
            end
            pos_next       = '0;
            head_good_next = 1'b0;
            all_ones_next  = 1'b1;
            dcrc_next      = CRC_INIT;
            ccrc_next      = CRC_INIT;
            dcrc_rx_next   = '0;
            ccrc_rx_next   = '0;
            cmd_next       = '0;
            addr_next      = '0;
        end
        else
        begin
            if (pos_reg >= POS_W'(1) && pos_reg < POS_W'(POS_CCRC))
            begin
                ccrc_next = crc16_byte(ccrc_reg, b);
            end
            if (pos_reg == '0)
            begin
                head_good_next = (b == cfg.head_byte);
            end
            else if (pos_reg == POS_W'(1))
            begin
                cmd_next = b;
            end
            else if (pos_reg < POS_W'(POS_DATA))
            begin
                addr_next = {addr_reg[ADDR_W-9:0], b};
            end
            else if (pos_reg < POS_W'(POS_DCRC))
            begin
                dcrc_next      = crc16_byte(dcrc_reg, b);
                all_ones_next  = all_ones_reg && (b == BLANK_BYTE);
                has_res        = 1'b1;
                res.kind       = KIND_DATA;
                res.data_byte  = b;
                res.data_index = IDX_W'(pos_reg - POS_W'(POS_DATA));
            end
            else if (pos_reg < POS_W'(POS_CCRC))
            begin
                dcrc_rx_next = {dcrc_rx_reg[7:0], b};
            end
            else
            begin
                ccrc_rx_next = {ccrc_rx_reg[7:0], b};
            end
        end
    end

    always_comb
    begin
        if (take && has_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            head_good_reg <= 1'b0;
            all_ones_reg  <= 1'b1;
            dcrc_reg      <= CRC_INIT;
            ccrc_reg      <= CRC_INIT;
            dcrc_rx_reg   <= '0;
            ccrc_rx_reg   <= '0;
            cmd_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pos_reg       <= pos_next;
                head_good_reg <= head_good_next;
                all_ones_reg  <= all_ones_next;
                dcrc_reg      <= dcrc_next;
                ccrc_reg      <= ccrc_next;
                dcrc_rx_reg   <= dcrc_rx_next;
                ccrc_rx_reg   <= ccrc_rx_next;
                cmd_reg       <= cmd_next;
                addr_reg      <= addr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && has_res)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.kind       = out_res_reg.kind;
    assign out_ch.data_byte  = out_res_reg.data_byte;
    assign out_ch.data_index = out_res_reg.data_index;
    assign out_ch.status     = out_res_reg.status;
    assign out_ch.cmd        = out_res_reg.cmd;
    assign out_ch.address    = out_res_reg.address;

    `UFC_ASSERT(pos_bounded, pos_reg <= POS_W'(POS_END), "Frame position ran past the end byte")
    `UFC_ASSERT(abort_restarts, take && s1_item.abort |=> pos_reg == '0 && !head_good_reg, "Abort did not restart the frame")
    `UFC_ASSERT(result_lands, take && has_res |=> out_valid_reg, "Result was lost on its way to the output register")
    `UFC_ASSERT(data_index_bounded, out_valid_reg && out_res_reg.kind == KIND_DATA |-> out_res_reg.data_index <= IDX_W'(DATA_BYTES - 1) && out_res_reg.status == ST_OK, "Data result out of range")

endmodule

`default_nettype wire

// ===== rtl/uart_frame_checker_core.sv =====
// ---------------------------------------------------------------------------
// UART frame checker core
// Checks fixed-length received frames byte by byte with CRC-16/Modbus.
// ---------------------------------------------------------------------------
//   Channel   Direction  Transfer
//   in_ch     sink       one received byte with its abort flag
//   out_ch    source     one data byte pass-through or one frame status
//   APB       slave      head byte, end byte and operation kind registers
//
// One byte is accepted every cycle when the output side keeps up.
// A result is offered once its byte transfer has loaded the input register
// and the engine's take has loaded the output register; a stall can delay that.
// The output register and input register let a new byte be taken while a
// result waits; a stalled output holds only bytes that produce a result.
// Reset is asynchronous and active low and clears all frame state at once.
`default_nettype none

module uart_frame_checker_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ufc_in_if.sink                          in_ch,
    ufc_out_if.source                       out_ch,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ufc_pkg::APB_AW-1:0] paddr,
    input  wire logic [ufc_pkg::APB_DW-1:0] pwdata,
    output logic      [ufc_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import ufc_pkg::*;

    cfg_t  cfg;
    logic  s1_valid;
    item_t s1_item;
    logic  take;

    ufc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ufc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .take     (take)
    );

    ufc_frame_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .take     (take),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire
